@@ src/hrfam_pkg.sv @@
// hrfam_pkg: shared types and constants for the hv rail fine adjust monitor
`timescale 1ns / 1ps
package hrfam_pkg;

  localparam int unsigned MAX_FINE_STEPS_DEF = 20;
  localparam int unsigned TIMER_BITS_DEF     = 16;

  localparam int unsigned MEAS_W = 15;
  localparam int unsigned CODE_W = 8;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned STEP_W = 8;

  localparam logic [CODE_W-1:0] POS_CLAMP_LO = 8'd137;
  localparam logic [CODE_W-1:0] POS_CLAMP_HI = 8'd208;
  localparam logic [CODE_W-1:0] NEG_CLAMP_LO = 8'd72;
  localparam logic [CODE_W-1:0] NEG_CLAMP_HI = 8'd245;
  localparam logic [MEAS_W:0]   DROOP_MARGIN = 16'd150;

  typedef enum logic [IDX_W-1:0] {
    REG_POS_WIN_LO  = 3'd0,
    REG_POS_WIN_HI  = 3'd1,
    REG_NEG_WIN_LO  = 3'd2,
    REG_NEG_WIN_HI  = 3'd3,
    REG_POS_TARGET  = 3'd4,
    REG_NEG_TARGET  = 3'd5,
    REG_TOLERANCE   = 3'd6,
    REG_WAIT_TIMEOUT = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [MEAS_W-1:0] pos_window_low;
    logic [MEAS_W-1:0] pos_window_high;
    logic [MEAS_W-1:0] neg_window_low;
    logic [MEAS_W-1:0] neg_window_high;
    logic [MEAS_W-1:0] pos_target;
    logic [MEAS_W-1:0] neg_target;
    logic [MEAS_W-1:0] tolerance;
    logic [CFG_W-1:0]  wait_timeout;
  } cfg_t;

  typedef struct packed {
    logic              cmd;
    logic [MEAS_W-1:0] vpp2_meas;
    logic [MEAS_W-1:0] vnn2_meas;
    logic [MEAS_W-1:0] vpp1_meas;
    logic [MEAS_W-1:0] vnn1_meas;
    logic [CODE_W-1:0] init_pos_code;
    logic [CODE_W-1:0] init_neg_code;
  } in_item_t;

  typedef struct packed {
    logic              dac_write;
    logic [CODE_W-1:0] pos_code;
    logic [CODE_W-1:0] neg_code;
    logic              adjust_done;
    logic              overvoltage_fault;
    logic              droop_fault;
    logic              shutdown;
    logic              waiting;
    logic              fine_active;
    logic              monitoring;
  } out_item_t;

endpackage

@@ src/hrfam_cfg_regs.sv @@
// hrfam_cfg_regs: configuration register file with plain write port
`timescale 1ns / 1ps
module hrfam_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hrfam_pkg::IDX_W-1:0]     cfg_idx_i,
  input  logic [hrfam_pkg::CFG_W-1:0]     cfg_wdata_i,
  output hrfam_pkg::cfg_t                 cfg_o
);

  hrfam_pkg::cfg_t cfg_q, cfg_d;
  logic [hrfam_pkg::MEAS_W-1:0] v15;

  assign v15 = cfg_wdata_i[hrfam_pkg::MEAS_W-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (hrfam_pkg::reg_idx_e'(cfg_idx_i))
        hrfam_pkg::REG_POS_WIN_LO:   cfg_d.pos_window_low  = v15;
        hrfam_pkg::REG_POS_WIN_HI:   cfg_d.pos_window_high = v15;
        hrfam_pkg::REG_NEG_WIN_LO:   cfg_d.neg_window_low  = v15;
        hrfam_pkg::REG_NEG_WIN_HI:   cfg_d.neg_window_high = v15;
        hrfam_pkg::REG_POS_TARGET:   cfg_d.pos_target      = v15;
        hrfam_pkg::REG_NEG_TARGET:   cfg_d.neg_target      = v15;
        hrfam_pkg::REG_TOLERANCE:    cfg_d.tolerance       = v15;
        hrfam_pkg::REG_WAIT_TIMEOUT: cfg_d.wait_timeout    = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pos_window_low  <= '0;
      cfg_q.pos_window_high <= '1;
      cfg_q.neg_window_low  <= '0;
      cfg_q.neg_window_high <= '1;
      cfg_q.pos_target      <= '0;
      cfg_q.neg_target      <= '0;
      cfg_q.tolerance       <= 15'd10;
      cfg_q.wait_timeout    <= 16'd100;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/hrfam_core.sv @@
// hrfam_core: adjust and monitor state with the per-tick update logic
`timescale 1ns / 1ps
module hrfam_core #(
  parameter int unsigned MAX_FINE_STEPS = hrfam_pkg::MAX_FINE_STEPS_DEF,
  parameter int unsigned TIMER_BITS     = hrfam_pkg::TIMER_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  hrfam_pkg::cfg_t       cfg_i,
  input  hrfam_pkg::in_item_t   item_i,
  output hrfam_pkg::out_item_t  res_o
);

  localparam int unsigned CW = (TIMER_BITS > hrfam_pkg::CFG_W) ? TIMER_BITS : hrfam_pkg::CFG_W;
  localparam int unsigned MW = hrfam_pkg::MEAS_W;
  localparam int unsigned KW = hrfam_pkg::CODE_W;
  localparam int unsigned SW = hrfam_pkg::STEP_W;

  logic                  wait_q, wait_d, fine_q, fine_d, mon_q, mon_d;
  logic [TIMER_BITS-1:0] wt_q, wt_d;
  logic [SW-1:0]         sc_q, sc_d;
  logic [KW-1:0]         pos_q, pos_d, neg_q, neg_d;

  logic [KW-1:0]         pos0, neg0;
  logic [TIMER_BITS-1:0] wt0, wt1;
  logic                  wf0, wf1, ff1, mf1;
  logic                  in_win, timed_out, wait_end, fin, wrote, ov, droop;
  logic [SW-1:0]         sc1, sc2;
  logic [MW-1:0]         adp, adn;
  logic                  pos_on, neg_on, pos_off, neg_off;

  function automatic logic [KW-1:0] step_code(input logic [KW-1:0] code, input logic up,
                                              input logic [KW-1:0] lo, input logic [KW-1:0] hi);
    logic [KW:0] inc;
    begin
      inc = {1'b0, code} + {{KW{1'b0}}, 1'b1};
      if (up) begin
        step_code = (inc >= {1'b0, hi}) ? hi : inc[KW-1:0];
      end else begin
        step_code = ({1'b0, code} <= {1'b0, lo} + {{KW{1'b0}}, 1'b1}) ? lo : code - 1'b1;
      end
    end
  endfunction

  always_comb begin
    pos0 = item_i.cmd ? item_i.init_pos_code : pos_q;
    neg0 = item_i.cmd ? item_i.init_neg_code : neg_q;
    wt0  = item_i.cmd ? '0 : wt_q;
    wf0  = item_i.cmd | wait_q;

    // wait phase
    in_win = (item_i.vpp2_meas >= cfg_i.pos_window_low)
          && (item_i.vpp2_meas <= cfg_i.pos_window_high)
          && (item_i.vnn2_meas >= cfg_i.neg_window_low)
          && (item_i.vnn2_meas <= cfg_i.neg_window_high);
    timed_out = CW'(wt0) > CW'(cfg_i.wait_timeout);
    wait_end  = wf0 & (timed_out | in_win);
    wf1 = wf0 & ~wait_end;
    ff1 = fine_q | wait_end;
    sc1 = wait_end ? '0 : sc_q;

    // fine phase
    sc2 = (ff1 && sc1 != '1) ? sc1 + 1'b1 : sc1;
    adp = (item_i.vpp2_meas >= cfg_i.pos_target) ? item_i.vpp2_meas - cfg_i.pos_target
                                                 : cfg_i.pos_target - item_i.vpp2_meas;
    adn = (item_i.vnn2_meas >= cfg_i.neg_target) ? item_i.vnn2_meas - cfg_i.neg_target
                                                 : cfg_i.neg_target - item_i.vnn2_meas;
    pos_on  = adp < cfg_i.tolerance;
    neg_on  = adn < cfg_i.tolerance;
    pos_off = adp > cfg_i.tolerance;
    neg_off = adn > cfg_i.tolerance;
    fin   = ff1 & ((sc2 >= SW'(MAX_FINE_STEPS)) | (pos_on & neg_on));
    wrote = ff1 & ~fin;
    sc_d  = fin ? '0 : sc2;
    wt1   = fin ? '0 : wt0;
    fine_d = ff1 & ~fin;
    mf1   = mon_q | fin;
    pos_d = (wrote && pos_off)
          ? step_code(pos0, item_i.vpp2_meas > cfg_i.pos_target,
                      hrfam_pkg::POS_CLAMP_LO, hrfam_pkg::POS_CLAMP_HI)
          : pos0;
    neg_d = (wrote && neg_off)
          ? step_code(neg0, item_i.vnn2_meas > cfg_i.neg_target,
                      hrfam_pkg::NEG_CLAMP_LO, hrfam_pkg::NEG_CLAMP_HI)
          : neg0;

    // monitor phase
    ov = mf1 & ((item_i.vpp2_meas >= cfg_i.pos_window_high)
             | (item_i.vnn2_meas >= cfg_i.neg_window_high));
    droop = mf1 & (({1'b0, item_i.vpp1_meas} + hrfam_pkg::DROOP_MARGIN < {1'b0, item_i.vpp2_meas})
                 | ({1'b0, item_i.vnn1_meas} + hrfam_pkg::DROOP_MARGIN < {1'b0, item_i.vnn2_meas}));
    mon_d = mf1 & ~(ov | droop);

    wait_d = wf1;
    wt_d   = (wf1 && wt1 != '1) ? wt1 + 1'b1 : wt1;

    res_o.dac_write         = wrote;
    res_o.pos_code          = pos_d;
    res_o.neg_code          = neg_d;
    res_o.adjust_done       = fin;
    res_o.overvoltage_fault = ov;
    res_o.droop_fault       = droop;
    res_o.shutdown          = ov | droop;
    res_o.waiting           = wait_d;
    res_o.fine_active       = fine_d;
    res_o.monitoring        = mon_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_q <= 1'b0;
      fine_q <= 1'b0;
      mon_q  <= 1'b0;
      wt_q   <= '0;
      sc_q   <= '0;
      pos_q  <= hrfam_pkg::POS_CLAMP_LO;
      neg_q  <= hrfam_pkg::NEG_CLAMP_LO;
    end else if (step_i) begin
      wait_q <= wait_d;
      fine_q <= fine_d;
      mon_q  <= mon_d;
      wt_q   <= wt_d;
      sc_q   <= sc_d;
      pos_q  <= pos_d;
      neg_q  <= neg_d;
    end
  end

endmodule

@@ src/hv_rail_fine_adjust_monitor_top.sv @@
// registers: accepted requests go to the input register, results to the result register
// throughput: one request per cycle while the output is not stalled; the per-tick update
// is a single pass of compare and step logic between the input register and the result register
// reset: asynchronous, active low; clears flags, counters and pipeline valids,
// sets dac codes to 137 and 72 and the configuration registers to their defaults
`timescale 1ns / 1ps
module hv_rail_fine_adjust_monitor_top #(
  parameter int unsigned MAX_FINE_STEPS = hrfam_pkg::MAX_FINE_STEPS_DEF,
  parameter int unsigned TIMER_BITS     = hrfam_pkg::TIMER_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hrfam_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [hrfam_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  hrfam_pkg::in_item_t           in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output hrfam_pkg::out_item_t          out_data_o
);

  hrfam_pkg::cfg_t      cfg;
  hrfam_pkg::in_item_t  in_q;
  hrfam_pkg::out_item_t res, out_q;
  logic                 in_vld_q, out_vld_q;
  logic                 s2_ready, s1_ready, step;

  assign s2_ready   = ~out_vld_q | out_ready_i;
  assign step       = in_vld_q & s2_ready;
  assign s1_ready   = ~in_vld_q | s2_ready;
  assign in_ready_o = s1_ready;

  hrfam_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  hrfam_core #(
    .MAX_FINE_STEPS (MAX_FINE_STEPS),
    .TIMER_BITS     (TIMER_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .cfg_i  (cfg),
    .item_i (in_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        in_vld_q <= in_valid_i;
      end
      if (s2_ready) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

@@ tb/hv_rail_fine_adjust_monitor_top_test.sv @@
// testbench for hv_rail_fine_adjust_monitor_top: rail tick sequences checked against a tick predictor
`timescale 1ns / 1ps
module hv_rail_fine_adjust_monitor_top_test;
  import hrfam_pkg::*;

  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_START   = 1'b1;
  localparam int   MEAS_MAX    = 32767;
  localparam int   CYCLE_LIMIT = 200000;
  localparam int   PHASES      = 12;
  localparam int   PHASE_ITEMS = 100;

  class rail_tick_checker;
    cfg_t                      regs;
    logic                      wait_flag, fine_flag, monitor_flag;
    logic [TIMER_BITS_DEF-1:0] wait_ticks;
    logic [STEP_W-1:0]         step_count;
    int                        pos_dac, neg_dac;
    out_item_t                 expected_ticks[$];
    int                        mismatches;

    function new();
      regs = '0;
      regs.pos_window_high = '1;
      regs.neg_window_high = '1;
      regs.tolerance = MEAS_W'(10);
      regs.wait_timeout = CFG_W'(100);
      wait_flag = 1'b0;
      fine_flag = 1'b0;
      monitor_flag = 1'b0;
      wait_ticks = '0;
      step_count = '0;
      pos_dac = int'(POS_CLAMP_LO);
      neg_dac = int'(NEG_CLAMP_LO);
      mismatches = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_POS_WIN_LO:   regs.pos_window_low = val[MEAS_W-1:0];
        REG_POS_WIN_HI:   regs.pos_window_high = val[MEAS_W-1:0];
        REG_NEG_WIN_LO:   regs.neg_window_low = val[MEAS_W-1:0];
        REG_NEG_WIN_HI:   regs.neg_window_high = val[MEAS_W-1:0];
        REG_POS_TARGET:   regs.pos_target = val[MEAS_W-1:0];
        REG_NEG_TARGET:   regs.neg_target = val[MEAS_W-1:0];
        REG_TOLERANCE:    regs.tolerance = val[MEAS_W-1:0];
        REG_WAIT_TIMEOUT: regs.wait_timeout = val;
        default: ;
      endcase
    endfunction

    function int step_toward(int code, int diff, int lo, int hi);
      if (diff > 0) return (code + 1 >= hi) ? hi : code + 1;
      if (diff < 0) return (code - 1 <= lo) ? lo : code - 1;
      return code;
    endfunction

    function out_item_t predict_tick(in_item_t it);
      int        vpp2, vnn2, vpp1, vnn1, tol, dp, dn, adp, adn;
      logic      ready;
      out_item_t r;
      r = '0;
      vpp2 = int'(it.vpp2_meas);
      vnn2 = int'(it.vnn2_meas);
      vpp1 = int'(it.vpp1_meas);
      vnn1 = int'(it.vnn1_meas);
      tol = int'(regs.tolerance);
      if (it.cmd == CMD_START) begin
        pos_dac = int'(it.init_pos_code);
        neg_dac = int'(it.init_neg_code);
        wait_ticks = '0;
        wait_flag = 1'b1;
      end
      if (wait_flag) begin
        ready = 1'b1;
        if (wait_ticks <= regs.wait_timeout) begin
          ready = vpp2 >= int'(regs.pos_window_low) && vpp2 <= int'(regs.pos_window_high) &&
                  vnn2 >= int'(regs.neg_window_low) && vnn2 <= int'(regs.neg_window_high);
        end
        if (ready) begin
          wait_flag = 1'b0;
          fine_flag = 1'b1;
          step_count = '0;
        end
      end
      if (fine_flag) begin
        if (step_count < 8'd255) step_count++;
        dp = vpp2 - int'(regs.pos_target);
        dn = vnn2 - int'(regs.neg_target);
        adp = (dp < 0) ? -dp : dp;
        adn = (dn < 0) ? -dn : dn;
        if (step_count >= MAX_FINE_STEPS_DEF || (adp < tol && adn < tol)) begin
          step_count = '0;
          wait_ticks = '0;
          fine_flag = 1'b0;
          monitor_flag = 1'b1;
          r.adjust_done = 1'b1;
        end else begin
          if (adp > tol) pos_dac = step_toward(pos_dac, dp, int'(POS_CLAMP_LO), int'(POS_CLAMP_HI));
          if (adn > tol) neg_dac = step_toward(neg_dac, dn, int'(NEG_CLAMP_LO), int'(NEG_CLAMP_HI));
          r.dac_write = 1'b1;
        end
      end
      if (monitor_flag) begin
        if (vpp2 >= int'(regs.pos_window_high) || vnn2 >= int'(regs.neg_window_high)) begin
          monitor_flag = 1'b0;
          r.overvoltage_fault = 1'b1;
        end
        if (vpp1 < vpp2 - int'(DROOP_MARGIN) || vnn1 < vnn2 - int'(DROOP_MARGIN)) begin
          monitor_flag = 1'b0;
          r.droop_fault = 1'b1;
        end
      end
      if (wait_flag && wait_ticks != '1) wait_ticks++;
      r.pos_code = CODE_W'(pos_dac);
      r.neg_code = CODE_W'(neg_dac);
      r.shutdown = r.overvoltage_fault | r.droop_fault;
      r.waiting = wait_flag;
      r.fine_active = fine_flag;
      r.monitoring = monitor_flag;
      return r;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task cmp_field(string name, logic [CODE_W-1:0] got, logic [CODE_W-1:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    function void note_tick(in_item_t it);
      expected_ticks.push_back(predict_tick(it));
    endfunction

    task check_tick(out_item_t got);
      out_item_t want;
      if (expected_ticks.size() == 0) begin
        report_mismatch("result with no pending request");
        return;
      end
      want = expected_ticks.pop_front();
      cmp_field("dac_write", got.dac_write, want.dac_write);
      cmp_field("pos_code", got.pos_code, want.pos_code);
      cmp_field("neg_code", got.neg_code, want.neg_code);
      cmp_field("adjust_done", got.adjust_done, want.adjust_done);
      cmp_field("overvoltage_fault", got.overvoltage_fault, want.overvoltage_fault);
      cmp_field("droop_fault", got.droop_fault, want.droop_fault);
      cmp_field("shutdown", got.shutdown, want.shutdown);
      cmp_field("waiting", got.waiting, want.waiting);
      cmp_field("fine_active", got.fine_active, want.fine_active);
      cmp_field("monitoring", got.monitoring, want.monitoring);
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  in_item_t          in_data = '0;
  logic              out_ready = 1'b0;
  logic              in_ready_o;
  logic              out_valid_o;
  out_item_t         out_data_o;
  logic              no_idle = 1'b0;
  int                items_sent = 0;
  int                cycles = 0;
  rail_tick_checker  sb;

  hv_rail_fine_adjust_monitor_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 32);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("hv_rail_fine_adjust_monitor_top_test NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready_o) sb.note_tick(in_data);
      if (out_valid_o && out_ready) sb.check_tick(out_data_o);
    end
  end

  task automatic send_tick(in_item_t it);
    while (!no_idle && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_ticks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(reg_idx_e idx, logic [CFG_W-1:0] val);
    // unused top bit of the narrow registers toggles at random
    if (idx != REG_WAIT_TIMEOUT) val[CFG_W-1] = 1'($urandom_range(1));
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic program_config(cfg_t c);
    put_reg(REG_POS_WIN_LO, CFG_W'(c.pos_window_low));
    put_reg(REG_POS_WIN_HI, CFG_W'(c.pos_window_high));
    put_reg(REG_NEG_WIN_LO, CFG_W'(c.neg_window_low));
    put_reg(REG_NEG_WIN_HI, CFG_W'(c.neg_window_high));
    put_reg(REG_POS_TARGET, CFG_W'(c.pos_target));
    put_reg(REG_NEG_TARGET, CFG_W'(c.neg_target));
    put_reg(REG_TOLERANCE, CFG_W'(c.tolerance));
    put_reg(REG_WAIT_TIMEOUT, c.wait_timeout);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [MEAS_W-1:0] clamp_meas(int v);
    if (v < 0) return '0;
    if (v > MEAS_MAX) return '1;
    return MEAS_W'(v);
  endfunction

  function automatic int in_span(int lo, int hi);
    if (lo > hi) return int'($urandom_range(MEAS_MAX));
    return int'($urandom_range(hi, lo));
  endfunction

  function automatic int outside_span(int lo, int hi);
    if (lo > 0 && (hi >= MEAS_MAX || $urandom_range(1))) return int'($urandom_range(lo - 1, 0));
    if (hi < MEAS_MAX) return int'($urandom_range(MEAS_MAX, hi + 1));
    return int'($urandom_range(MEAS_MAX));
  endfunction

  function automatic int healthy_sag();
    return int'($urandom_range(300)) - 150;
  endfunction

  function automatic int near_offset(int tol);
    if (tol <= 1) return 0;
    return int'($urandom_range(2 * (tol - 1))) - (tol - 1);
  endfunction

  function automatic in_item_t make_item(logic cmd, int vpp2, int vnn2, int sag_p, int sag_n);
    in_item_t it;
    it.cmd = cmd;
    it.vpp2_meas = clamp_meas(vpp2);
    it.vnn2_meas = clamp_meas(vnn2);
    it.vpp1_meas = clamp_meas(int'(it.vpp2_meas) - sag_p);
    it.vnn1_meas = clamp_meas(int'(it.vnn2_meas) - sag_n);
    it.init_pos_code = CODE_W'($urandom_range(255));
    it.init_neg_code = CODE_W'($urandom_range(255));
    return it;
  endfunction

  initial begin
    cfg_t     setting;
    in_item_t it;
    int       plo, phi, nlo, nhi, pt, nt, tol, spread, k, f, m, goal;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration: start with codes outside the clamps, settle, overvoltage
    it = make_item(CMD_START, MEAS_MAX, 0, 0, 0);
    it.init_pos_code = 8'd255;
    it.init_neg_code = 8'd0;
    send_tick(it);
    send_tick(make_item(CMD_TICK, 5, 5, 0, 0));
    it = '1;
    it.cmd = CMD_TICK;
    send_tick(it);
    settle();

    setting.pos_window_low = MEAS_W'(500);
    setting.pos_window_high = MEAS_W'(3000);
    setting.neg_window_low = MEAS_W'(400);
    setting.neg_window_high = MEAS_W'(2500);
    setting.pos_target = MEAS_W'(1000);
    setting.neg_target = MEAS_W'(900);
    setting.tolerance = MEAS_W'(10);
    setting.wait_timeout = CFG_W'(3);
    program_config(setting);

    send_tick('0);
    // rails stay out of window until the wait times out
    it = make_item(CMD_START, 0, MEAS_MAX, 0, 0);
    it.init_pos_code = 8'd255;
    it.init_neg_code = 8'd0;
    send_tick(it);
    repeat (4) send_tick(make_item(CMD_TICK, 0, MEAS_MAX, 0, 0));
    // difference equal to tolerance, then just inside it
    send_tick(make_item(CMD_TICK, 1010, 890, 0, 0));
    send_tick(make_item(CMD_TICK, 1009, 891, 150, 150));
    send_tick(make_item(CMD_TICK, 2000, 1000, 0, 151));
    // codes at the clamp edges stepped into the clamps
    it = make_item(CMD_START, 500, 2500, 0, 0);
    it.init_pos_code = POS_CLAMP_LO;
    it.init_neg_code = NEG_CLAMP_LO;
    send_tick(it);
    send_tick(make_item(CMD_TICK, 3000, 400, 0, 0));
    // restart while fine adjust is active
    it = make_item(CMD_START, 3000, 2500, 0, 0);
    it.init_pos_code = POS_CLAMP_HI;
    it.init_neg_code = NEG_CLAMP_HI;
    send_tick(it);
    send_tick(make_item(CMD_TICK, 1000, 900, 0, 0));
    send_tick(make_item(CMD_TICK, 3000, 2500, 151, 151));
    it = '1;
    it.cmd = CMD_TICK;
    send_tick(it);
    it = make_item(CMD_START, 1000, 900, 0, 0);
    it.init_pos_code = 8'd0;
    it.init_neg_code = 8'd255;
    send_tick(it);
    send_tick(make_item(CMD_TICK, 1500, 1200, -150, 150));
    settle();

    for (int p = 0; p < PHASES; p++) begin
      no_idle = (p == 4 || p == 5);
      plo = int'($urandom_range(20000));
      phi = plo + int'($urandom_range(8000, 300));
      nlo = int'($urandom_range(20000));
      nhi = nlo + int'($urandom_range(8000, 300));
      setting.pos_window_low = MEAS_W'(plo);
      setting.pos_window_high = MEAS_W'(phi);
      setting.neg_window_low = MEAS_W'(nlo);
      setting.neg_window_high = MEAS_W'(nhi);
      setting.pos_target = MEAS_W'($urandom_range(phi - 100, plo + 100));
      setting.neg_target = MEAS_W'($urandom_range(nhi - 100, nlo + 100));
      setting.tolerance = MEAS_W'($urandom_range(60, 1));
      setting.wait_timeout = CFG_W'($urandom_range(8));
      case (p % 6)
        2: begin
          setting.tolerance = '0;
          setting.wait_timeout = '0;
        end
        3: begin
          setting.tolerance = '1;
          setting.wait_timeout = '1;
        end
        4: begin
          setting.pos_window_low = '0;
          setting.pos_window_high = '1;
          setting.neg_window_low = '0;
          setting.neg_window_high = '1;
        end
        5: begin
          // empty windows: every wait times out, every monitored tick is overvoltage
          setting.pos_window_low = '1;
          setting.pos_window_high = '0;
          setting.neg_window_low = '1;
          setting.neg_window_high = '0;
          setting.wait_timeout = CFG_W'($urandom_range(2));
        end
        default: ;
      endcase
      program_config(setting);

      plo = int'(sb.regs.pos_window_low);
      phi = int'(sb.regs.pos_window_high);
      nlo = int'(sb.regs.neg_window_low);
      nhi = int'(sb.regs.neg_window_high);
      pt = int'(sb.regs.pos_target);
      nt = int'(sb.regs.neg_target);
      tol = int'(sb.regs.tolerance);
      spread = (tol > 600) ? 2000 : tol * 3 + 20;
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) begin
        if ($urandom_range(99) < 20) begin
          it = make_item(1'($urandom_range(1)), int'($urandom_range(MEAS_MAX)),
                         int'($urandom_range(MEAS_MAX)), 0, 0);
          it.vpp1_meas = MEAS_W'($urandom_range(MEAS_MAX));
          it.vnn1_meas = MEAS_W'($urandom_range(MEAS_MAX));
          send_tick(it);
        end else begin
          k = int'($urandom_range(4));
          if (k == 0) begin
            it = make_item(CMD_START, in_span(plo, phi), in_span(nlo, nhi),
                           healthy_sag(), healthy_sag());
          end else begin
            it = make_item(CMD_START, outside_span(plo, phi), outside_span(nlo, nhi),
                           healthy_sag(), healthy_sag());
          end
          if ($urandom_range(1)) begin
            it.init_pos_code = CODE_W'($urandom_range(215, 130));
            it.init_neg_code = CODE_W'($urandom_range(250, 65));
          end
          send_tick(it);
          for (int i = 1; i < k; i++) begin
            send_tick(make_item(CMD_TICK, outside_span(plo, phi), outside_span(nlo, nhi),
                                healthy_sag(), healthy_sag()));
          end
          if (k > 0) begin
            send_tick(make_item(CMD_TICK, in_span(plo, phi), in_span(nlo, nhi),
                                healthy_sag(), healthy_sag()));
          end
          f = int'($urandom_range(24));
          for (int i = 0; i < f; i++) begin
            send_tick(make_item(CMD_TICK, pt + int'($urandom_range(2 * spread)) - spread,
                                nt + int'($urandom_range(2 * spread)) - spread,
                                healthy_sag(), healthy_sag()));
          end
          if ($urandom_range(1)) begin
            send_tick(make_item(CMD_TICK, pt + near_offset(tol), nt + near_offset(tol),
                                healthy_sag(), healthy_sag()));
          end
          m = int'($urandom_range(6, 1));
          for (int i = 1; i < m; i++) begin
            send_tick(make_item(CMD_TICK, in_span(plo, phi - 1), in_span(nlo, nhi - 1),
                                healthy_sag(), healthy_sag()));
          end
          case ($urandom_range(3))
            0: it = make_item(CMD_TICK, phi + int'($urandom_range(3)), in_span(nlo, nhi),
                              healthy_sag(), healthy_sag());
            1: it = make_item(CMD_TICK, in_span(plo, phi - 1), in_span(nlo, nhi - 1),
                              151 + int'($urandom_range(400)), healthy_sag());
            2: it = make_item(CMD_TICK, in_span(plo, phi - 1), in_span(nlo, nhi - 1),
                              healthy_sag(), 151 + int'($urandom_range(400)));
            default: it = make_item(CMD_TICK, in_span(plo, phi - 1), in_span(nlo, nhi - 1),
                                    healthy_sag(), healthy_sag());
          endcase
          send_tick(it);
        end
      end
      settle();
    end

    if (sb.mismatches == 0 && sb.expected_ticks.size() == 0) begin
      $display("hv_rail_fine_adjust_monitor_top_test OK");
    end else begin
      $display("hv_rail_fine_adjust_monitor_top_test NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/hrfam_pkg.sv
src/hrfam_cfg_regs.sv
src/hrfam_core.sv
src/hv_rail_fine_adjust_monitor_top.sv
tb/hv_rail_fine_adjust_monitor_top_test.sv
